// ===== src/sfcd_pkg.sv =====
// shared types, constants and the crc-8 step for the sensor frame decoder
package sfcd_pkg;

	// frame layout
	localparam logic [3:0] FRAME_LEN   = 4'd9;
	localparam logic [3:0] POS_CRC_A   = 4'd2;
	localparam logic [3:0] POS_CRC_B   = 4'd5;
	localparam logic [3:0] POS_CRC_C   = 4'd8;
	localparam logic [3:0] POS_TEMP_HI = 4'd6;

	// crc-8, polynomial 0x31, msb first
	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_MSB  = 8'h80;

	// fahrenheit offset in hundredths (32 degrees)
	localparam logic signed [16:0] TEMP_OFFSET = 17'sd3200;

	// division by nine as multiply by ceil(2^23 / 9), exact for values below 2^19
	localparam int unsigned RECIP_SHIFT = 23;
	localparam logic [19:0] RECIP_NINE  = 20'd932068;

	// magnitude width of (raw - offset) * 5
	localparam int unsigned MAG_W  = 19;
	localparam int unsigned TEMP_W = 17;

	typedef logic [MAG_W-1:0]         mag_t;
	typedef logic signed [TEMP_W-1:0] temp_t;

	// one byte through the crc register, eight shift steps
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_MSB) != 8'h00) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== src/sfcd_if.sv =====
// valid/ready channel interfaces for received bytes and decoded results

interface sfcd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;

	modport source (output valid, output rx_byte, output frame_start, input ready);
	modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface sfcd_res_if;
	logic                  valid;
	logic                  ready;
	logic                  status;
	logic [31:0]           co2_ppm;
	sfcd_pkg::temp_t       temp_centi_c;

	modport source (output valid, output status, output co2_ppm, output temp_centi_c,
		input ready);
	modport sink   (input valid, input status, input co2_ppm, input temp_centi_c,
		output ready);
endinterface

// ===== src/sensor_frame_crc8_decoder.sv =====
// top level: nine-byte sensor frame decoder with crc-8 checks per group
//
// Bytes enter on rx, one item per byte, frame_start marking byte 0 of a frame.
// Each group of two data bytes and a crc byte is checked with crc-8 (0x31,
// init 0xFF). After the ninth byte one result item leaves on res with status,
// co2_ppm (bytes 0,1,3,4) and temp_centi_c; on a crc failure the two values
// are zero. Bytes after the ninth without frame_start are dropped.
// Throughput: one byte per cycle while rx.ready is high. Frame state is updated as the
// byte is taken; the ninth byte loads stage s1 (offset, scale by five, magnitude), and
// from s1 the output register takes the reciprocal-multiply division by nine.
// A stalled receiver holds the result in the output register while s1 holds
// one more; rx.ready drops only when both are full.
// Reset clears the frame position and flags and sets the crc to 0xFF; the
// first bytes after reset continue a frame from byte 0.
module sensor_frame_crc8_decoder (
	input  logic               clk,
	input  logic               arst_n,
	sfcd_rx_if.sink            rx,
	sfcd_res_if.source         res
);

	// frame state
	logic [3:0]  pos_q;
	logic [7:0]  crc_q;
	logic [31:0] co2_q;
	logic [15:0] raw_q;
	logic        err_q;

	// stage s1 and output register
	logic              valid_s1;
	logic              status_s1;
	logic [31:0]       co2_s1;
	sfcd_pkg::mag_t    mag_s1;
	logic              neg_s1;
	logic              out_valid_q;
	logic              status_q;
	logic [31:0]       co2_out_q;
	sfcd_pkg::temp_t   temp_out_q;

	logic            accept;
	logic            adv_s1;
	logic [3:0]      pos_eff;
	logic [7:0]      crc_eff;
	logic [31:0]     co2_eff;
	logic [15:0]     raw_eff;
	logic            err_eff;
	logic            in_frame;
	logic            is_crc;
	logic            done;
	logic            err_new;
	logic signed [16:0] diff;
	logic signed [19:0] scaled;
	sfcd_pkg::mag_t  mag;
	sfcd_pkg::temp_t temp_conv;

	// handshake
	assign adv_s1   = !out_valid_q || res.ready;
	assign rx.ready = !valid_s1 || adv_s1;
	assign accept   = rx.valid && rx.ready;

	// state seen by this byte, cleared on frame start (crc set to its init value)
	always_comb begin
		pos_eff  = rx.frame_start ? 4'd0 : pos_q;
		crc_eff  = rx.frame_start ? sfcd_pkg::CRC_INIT : crc_q;
		co2_eff  = rx.frame_start ? 32'd0 : co2_q;
		raw_eff  = rx.frame_start ? 16'd0 : raw_q;
		err_eff  = rx.frame_start ? 1'b0 : err_q;
		in_frame = pos_eff < sfcd_pkg::FRAME_LEN;
		is_crc   = (pos_eff == sfcd_pkg::POS_CRC_A) || (pos_eff == sfcd_pkg::POS_CRC_B) ||
			(pos_eff == sfcd_pkg::POS_CRC_C);
		done     = pos_eff == sfcd_pkg::POS_CRC_C;
		err_new  = err_eff || (is_crc && (rx.rx_byte != crc_eff));
	end

	// temperature offset, times five, split into sign and magnitude
	always_comb begin
		diff   = $signed({1'b0, raw_eff}) - sfcd_pkg::TEMP_OFFSET;
		scaled = 20'(diff) + (20'(diff) <<< 2);
		mag    = scaled[19] ? sfcd_pkg::mag_t'(-scaled) : sfcd_pkg::mag_t'(scaled);
	end

	// frame state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 4'd0;
			crc_q <= sfcd_pkg::CRC_INIT;
			co2_q <= 32'd0;
			raw_q <= 16'd0;
			err_q <= 1'b0;
		end else if (accept) begin
			if (in_frame) begin
				pos_q <= pos_eff + 4'd1;
				err_q <= err_new;
				crc_q <= is_crc ? sfcd_pkg::CRC_INIT : sfcd_pkg::crc8_update(crc_eff, rx.rx_byte);
				if (!is_crc && pos_eff < sfcd_pkg::POS_TEMP_HI) begin
					co2_q <= {co2_eff[23:0], rx.rx_byte};
				end else begin
					co2_q <= co2_eff;
				end
				if (!is_crc && pos_eff >= sfcd_pkg::POS_TEMP_HI) begin
					raw_q <= {raw_eff[7:0], rx.rx_byte};
				end else begin
					raw_q <= raw_eff;
				end
			end else begin
				pos_q <= pos_eff;
			end
		end
	end

	// stage s1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && done) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage s1 payload
	always_ff @(posedge clk) begin
		if (accept && done) begin
			status_s1 <= err_new;
			co2_s1    <= co2_eff;
			mag_s1    <= mag;
			neg_s1    <= scaled[19];
		end
	end

	sfcd_temp_conv u_conv (
		.mag  (mag_s1),
		.neg  (neg_s1),
		.temp (temp_conv)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	// output register payload, values forced to zero on crc failure
	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			status_q   <= status_s1;
			co2_out_q  <= status_s1 ? 32'd0 : co2_s1;
			temp_out_q <= status_s1 ? '0 : temp_conv;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.status       = status_q;
	assign res.co2_ppm      = co2_out_q;
	assign res.temp_centi_c = temp_out_q;

	// position never runs past the frame length
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= sfcd_pkg::FRAME_LEN)
		else $error("frame position beyond frame length");

	// a failed frame carries zero values
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status) |-> (res.co2_ppm == 32'd0 && res.temp_centi_c == '0))
		else $error("failed frame with nonzero values");

	// the last byte of a frame fills stage s1
	a_done_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && done) |=> valid_s1)
		else $error("frame end lost before stage s1");

	// no byte taken while both result stages are full and stalled
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !res.ready) |-> !rx.ready)
		else $error("byte taken with full pipeline");

endmodule

// ===== src/sfcd_temp_conv.sv =====
// magnitude of (raw - 3200) * 5 divided by nine with sign restored
module sfcd_temp_conv (
	input  sfcd_pkg::mag_t  mag,
	input  logic            neg,
	output sfcd_pkg::temp_t temp
);

	logic [38:0] prod;
	logic [15:0] quot;

	// reciprocal multiply, quotient truncated
	always_comb begin
		prod = 39'(mag) * 39'(sfcd_pkg::RECIP_NINE);
		quot = prod[sfcd_pkg::RECIP_SHIFT +: 16];
	end

	// truncation toward zero: negate the magnitude quotient
	assign temp = neg ? -sfcd_pkg::temp_t'({1'b0, quot}) : sfcd_pkg::temp_t'({1'b0, quot});

endmodule
